FILE: hdl/png_ssw_pkg.sv
// Shared constants, register indexes and the CRC-32 nibble table for the PNG stream writer.
`timescale 1ns / 1ps
`default_nettype none

package png_ssw_pkg;

    localparam int unsigned MAX_WIDTH  = 16383;
    localparam int unsigned MAX_HEIGHT = 32768;

    localparam logic [15:0] ADLER_MOD = 16'd65521;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_ALPHA_MODE   = 2'd2
    } cfg_reg_t;

    // Segments of the byte sequence that one input transaction can cause.
    localparam int unsigned HDR_LAST = 42;
    localparam int unsigned ROW_LAST = 5;
    localparam int unsigned TRL_LAST = 19;

    function automatic logic [31:0] crc_nibble(input logic [3:0] n);
        logic [31:0] t;
        begin
            case (n)
                4'h0:    t = 32'h00000000;
                4'h1:    t = 32'h1db71064;
                4'h2:    t = 32'h3b6e20c8;
                4'h3:    t = 32'h26d930ac;
                4'h4:    t = 32'h76dc4190;
                4'h5:    t = 32'h6b6b51f4;
                4'h6:    t = 32'h4db26158;
                4'h7:    t = 32'h5005713c;
                4'h8:    t = 32'hedb88320;
                4'h9:    t = 32'hf00f9344;
                4'ha:    t = 32'hd6d6a3e8;
                4'hb:    t = 32'hcb61b38c;
                4'hc:    t = 32'h9b64c2b0;
                4'hd:    t = 32'h86d3d2d4;
                4'he:    t = 32'ha00ae278;
                default: t = 32'hbdbdf21c;
            endcase
            return t;
        end
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        begin
            c = crc ^ {24'd0, b};
            c = (c >> 4) ^ crc_nibble(c[3:0]);
            c = (c >> 4) ^ crc_nibble(c[3:0]);
            return c;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/png_stored_stream_writer_core.sv
// Top level of the uncompressed PNG stream writer: byte sequencer, checksums and stream ports.
// Each accepted input byte is held in pix_reg, and every output byte is registered in out_data_reg.
// One output byte per cycle unless the output stalls; the first byte of an image also emits
// the file and row headers, a later row's first byte its row header, the last the trailer.
// A new input transaction is taken in the cycle in which the previous one emits its last byte.
// rst_n is asynchronous and active low; it clears all control state and sets the registers
// to width 1, height 1 and RGB.
`timescale 1ns / 1ps
`default_nettype none

module png_stored_stream_writer_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,   // [7:0] pixel_byte
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [7:0]                              m_axis_tdata,   // [7:0] out_byte
    output logic                                    m_axis_tlast,   // last_of_run
    output logic                                    m_axis_tuser,   // [0] file_end
    input  wire logic                               cfg_we,
    input  wire logic [png_ssw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [png_ssw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import png_ssw_pkg::*;

    typedef enum logic [2:0] {
        SEG_START,
        SEG_HDR,
        SEG_ROW,
        SEG_PIX,
        SEG_TRL
    } seg_t;

    logic [13:0] cfg_width_reg;
    logic [15:0] cfg_height_reg;
    logic        cfg_alpha_reg;
    logic [31:0] idat_len_reg;

    logic [31:0] crc_reg;
    logic [15:0] adler_lo_reg;
    logic [15:0] adler_hi_reg;
    logic [15:0] col_reg;
    logic [14:0] row_reg;
    logic        hdr_sent_reg;
    seg_t        seg_reg;
    logic [5:0]  idx_reg;
    logic [7:0]  pix_reg;
    logic        pix_valid_reg;

    logic [7:0]  out_data_reg;
    logic        out_last_reg;
    logic        out_end_reg;
    logic        out_valid_reg;

    logic [15:0] width_eff;
    logic [15:0] height_eff;
    logic [15:0] row_bytes;
    logic [15:0] pitch;
    logic [31:0] idat_len_next;
    logic        last_row;
    logic [15:0] col_next;
    logic        row_end;

    seg_t        seg_cur;
    logic [5:0]  idx_cur;
    seg_t        seg_next;
    logic [5:0]  idx_next;
    logic [7:0]  byte_val;
    logic        byte_last;
    logic        byte_end;
    logic        crc_en;
    logic        crc_init;
    logic        adler_en;
    logic        hdr_done;
    logic        pix_step;
    logic        trl_done;

    logic [31:0] crc_base;
    logic [31:0] crc_next;
    logic [16:0] lo_sum;
    logic [15:0] adler_lo_next;
    logic [16:0] hi_sum;
    logic [15:0] adler_hi_next;

    logic        advance;
    logic        item_done;
    logic        in_take;

    always_comb
    begin
        width_eff = (cfg_width_reg == 14'd0) ? 16'd1 : {2'b00, cfg_width_reg};
        if (cfg_height_reg == 16'd0)
        begin
            height_eff = 16'd1;
        end
        else if (cfg_height_reg > 16'(MAX_HEIGHT))
        begin
            height_eff = 16'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = cfg_height_reg;
        end
        row_bytes = cfg_alpha_reg ? (width_eff << 2) : (width_eff + (width_eff << 1));
        pitch = row_bytes + 16'd1;
        idat_len_next = ({16'd0, height_eff} * ({16'd0, pitch} + 32'd5)) + 32'd6;
        last_row = ({1'b0, row_reg} + 16'd1) >= height_eff;
        col_next = col_reg + 16'd1;
        row_end = col_next >= row_bytes;
    end

    always_comb
    begin
        if (seg_reg == SEG_START)
        begin
            idx_cur = 6'd0;
            if (!hdr_sent_reg)
            begin
                seg_cur = SEG_HDR;
            end
            else if (col_reg == 16'd0)
            begin
                seg_cur = SEG_ROW;
            end
            else
            begin
                seg_cur = SEG_PIX;
            end
        end
        else
        begin
            seg_cur = seg_reg;
            idx_cur = idx_reg;
        end
    end

    always_comb
    begin
        byte_val  = 8'h00;
        byte_last = 1'b0;
        byte_end  = 1'b0;
        crc_en    = 1'b0;
        crc_init  = 1'b0;
        adler_en  = 1'b0;
        hdr_done  = 1'b0;
        pix_step  = 1'b0;
        trl_done  = 1'b0;
        seg_next  = seg_cur;
        idx_next  = idx_cur + 6'd1;
        case (seg_cur)
            SEG_HDR:
            begin
                crc_en   = ((idx_cur >= 6'd12) && (idx_cur <= 6'd28)) || (idx_cur >= 6'd37);
                crc_init = (idx_cur == 6'd12) || (idx_cur == 6'd37);
                case (idx_cur)
                    6'd0:    byte_val = 8'h89;
                    6'd1:    byte_val = 8'h50;
                    6'd2:    byte_val = 8'h4e;
                    6'd3:    byte_val = 8'h47;
                    6'd4:    byte_val = 8'h0d;
                    6'd5:    byte_val = 8'h0a;
                    6'd6:    byte_val = 8'h1a;
                    6'd7:    byte_val = 8'h0a;
                    6'd11:   byte_val = 8'h0d;
                    6'd12:   byte_val = 8'h49;
                    6'd13:   byte_val = 8'h48;
                    6'd14:   byte_val = 8'h44;
                    6'd15:   byte_val = 8'h52;
                    6'd18:   byte_val = width_eff[15:8];
                    6'd19:   byte_val = width_eff[7:0];
                    6'd22:   byte_val = height_eff[15:8];
                    6'd23:   byte_val = height_eff[7:0];
                    6'd24:   byte_val = 8'h08;
                    6'd25:   byte_val = cfg_alpha_reg ? 8'h06 : 8'h02;
                    6'd29:   byte_val = ~crc_reg[31:24];
                    6'd30:   byte_val = ~crc_reg[23:16];
                    6'd31:   byte_val = ~crc_reg[15:8];
                    6'd32:   byte_val = ~crc_reg[7:0];
                    6'd33:   byte_val = idat_len_reg[31:24];
                    6'd34:   byte_val = idat_len_reg[23:16];
                    6'd35:   byte_val = idat_len_reg[15:8];
                    6'd36:   byte_val = idat_len_reg[7:0];
                    6'd37:   byte_val = 8'h49;
                    6'd38:   byte_val = 8'h44;
                    6'd39:   byte_val = 8'h41;
                    6'd40:   byte_val = 8'h54;
                    6'd41:   byte_val = 8'h78;
                    6'd42:   byte_val = 8'h01;
                    default: byte_val = 8'h00;
                endcase
                if (idx_cur == 6'(HDR_LAST))
                begin
                    hdr_done = 1'b1;
                    seg_next = SEG_ROW;
                    idx_next = 6'd0;
                end
            end
            SEG_ROW:
            begin
                crc_en = 1'b1;
                case (idx_cur)
                    6'd0:    byte_val = {7'd0, last_row};
                    6'd1:    byte_val = pitch[7:0];
                    6'd2:    byte_val = pitch[15:8];
                    6'd3:    byte_val = ~pitch[7:0];
                    6'd4:    byte_val = ~pitch[15:8];
                    default: byte_val = 8'h00;
                endcase
                if (idx_cur == 6'(ROW_LAST))
                begin
                    adler_en = 1'b1;
                    seg_next = SEG_PIX;
                    idx_next = 6'd0;
                end
            end
            SEG_PIX:
            begin
                byte_val = pix_reg;
                crc_en   = 1'b1;
                adler_en = 1'b1;
                pix_step = 1'b1;
                idx_next = 6'd0;
                if (row_end && last_row)
                begin
                    seg_next = SEG_TRL;
                end
                else
                begin
                    byte_last = 1'b1;
                end
            end
            SEG_TRL:
            begin
                crc_en   = (idx_cur <= 6'd3) || ((idx_cur >= 6'd12) && (idx_cur <= 6'd15));
                crc_init = (idx_cur == 6'd12);
                case (idx_cur)
                    6'd0:    byte_val = adler_hi_reg[15:8];
                    6'd1:    byte_val = adler_hi_reg[7:0];
                    6'd2:    byte_val = adler_lo_reg[15:8];
                    6'd3:    byte_val = adler_lo_reg[7:0];
                    6'd4:    byte_val = ~crc_reg[31:24];
                    6'd5:    byte_val = ~crc_reg[23:16];
                    6'd6:    byte_val = ~crc_reg[15:8];
                    6'd7:    byte_val = ~crc_reg[7:0];
                    6'd12:   byte_val = 8'h49;
                    6'd13:   byte_val = 8'h45;
                    6'd14:   byte_val = 8'h4e;
                    6'd15:   byte_val = 8'h44;
                    6'd16:   byte_val = ~crc_reg[31:24];
                    6'd17:   byte_val = ~crc_reg[23:16];
                    6'd18:   byte_val = ~crc_reg[15:8];
                    6'd19:   byte_val = ~crc_reg[7:0];
                    default: byte_val = 8'h00;
                endcase
                if (idx_cur == 6'(TRL_LAST))
                begin
                    byte_last = 1'b1;
                    byte_end  = 1'b1;
                    trl_done  = 1'b1;
                    idx_next  = 6'd0;
                end
            end
            default:
            begin
                byte_val = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        crc_base = crc_init ? 32'hffffffff : crc_reg;
        crc_next = crc_byte(crc_base, byte_val);
        lo_sum = {1'b0, adler_lo_reg} + {9'd0, byte_val};
        adler_lo_next = (lo_sum >= {1'b0, ADLER_MOD}) ? 16'(lo_sum - {1'b0, ADLER_MOD})
                                                      : lo_sum[15:0];
        hi_sum = {1'b0, adler_hi_reg} + {1'b0, adler_lo_next};
        adler_hi_next = (hi_sum >= {1'b0, ADLER_MOD}) ? 16'(hi_sum - {1'b0, ADLER_MOD})
                                                      : hi_sum[15:0];
    end

    assign advance       = pix_valid_reg && (!out_valid_reg || m_axis_tready);
    assign item_done     = advance && byte_last;
    assign s_axis_tready = !pix_valid_reg || item_done;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= 14'd1;
            cfg_height_reg <= 16'd1;
            cfg_alpha_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_wdata[13:0];
                REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_wdata[15:0];
                REG_ALPHA_MODE:   cfg_alpha_reg  <= cfg_wdata[0];
                default:          cfg_alpha_reg  <= cfg_alpha_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        idat_len_reg <= idat_len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= 32'hffffffff;
            adler_lo_reg  <= 16'd1;
            adler_hi_reg  <= 16'd0;
            col_reg       <= 16'd0;
            row_reg       <= 15'd0;
            hdr_sent_reg  <= 1'b0;
            seg_reg       <= SEG_START;
            idx_reg       <= 6'd0;
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= byte_val;
                out_last_reg  <= byte_last;
                out_end_reg   <= byte_end;
                if (crc_en)
                begin
                    crc_reg <= crc_next;
                end
                if (adler_en)
                begin
                    adler_lo_reg <= adler_lo_next;
                    adler_hi_reg <= adler_hi_next;
                end
                if (hdr_done)
                begin
                    adler_lo_reg <= 16'd1;
                    adler_hi_reg <= 16'd0;
                    col_reg      <= 16'd0;
                    row_reg      <= 15'd0;
                    hdr_sent_reg <= 1'b1;
                end
                if (pix_step)
                begin
                    col_reg <= row_end ? 16'd0 : col_next;
                    if (row_end && !last_row)
                    begin
                        row_reg <= row_reg + 15'd1;
                    end
                end
                if (trl_done)
                begin
                    adler_lo_reg <= 16'd1;
                    adler_hi_reg <= 16'd0;
                    row_reg      <= 15'd0;
                    hdr_sent_reg <= 1'b0;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_take)
            begin
                pix_reg       <= s_axis_tdata;
                pix_valid_reg <= 1'b1;
                seg_reg       <= SEG_START;
                idx_reg       <= 6'd0;
            end
            else
            begin
                if (advance)
                begin
                    seg_reg <= seg_next;
                    idx_reg <= idx_next;
                end
                if (item_done)
                begin
                    pix_valid_reg <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // The end-of-file mark only ever travels on the last byte of a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("file end flagged on a byte that is not the last of its transaction");

    // Both Adler-32 sums stay reduced modulo 65521.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adler_lo_reg < ADLER_MOD) && (adler_hi_reg < ADLER_MOD))
        else $error("Adler-32 sum out of range");

    // Outside an image the column count rests at zero, so the next row header is sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        !hdr_sent_reg |-> (col_reg == 16'd0))
        else $error("column count not cleared outside an image");

    // Row headers and pixel bytes are only emitted once the file header has gone out.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (seg_cur == SEG_ROW || seg_cur == SEG_PIX) |-> hdr_sent_reg)
        else $error("image data emitted before the file header");

    // Finishing the trailer closes the file.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && trl_done |=> !hdr_sent_reg && (row_reg == 15'd0))
        else $error("file state not cleared after the trailer");
`endif

endmodule

`default_nettype wire

FILE: verif/png_ssw_stream_checker.sv
// Checker that predicts the PNG byte stream from observed transactions and compares the output.
`timescale 1ns / 1ps

module png_ssw_stream_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,   // [7:0] pixel_byte
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [7:0]                         m_axis_tdata,   // [7:0] out_byte
    input  wire logic                               m_axis_tlast,   // last_of_run
    input  wire logic                               m_axis_tuser,   // [0] file_end
    input  wire logic                               cfg_we,
    input  wire logic [png_ssw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [png_ssw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                      fail_count,
    output int                                      pending,
    output logic                                    image_open
);

    import png_ssw_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fend;
    } png_out_t;

    png_out_t    png_bytes_due[$];
    logic [7:0]  step_bytes[$];

    logic [13:0] width_reg = 14'd1;
    logic [15:0] height_reg = 16'd1;
    logic        alpha_reg = 1'b0;
    logic [31:0] crc_acc = '1;
    int unsigned adler_a = 1;
    int unsigned adler_b = 0;
    logic [15:0] col_cnt = '0;
    logic [14:0] row_cnt = '0;

    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        int          i;
        r = c ^ {24'd0, b};
        for (i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ 32'hedb88320) : (r >> 1);
        return r;
    endfunction

    task automatic put_plain(input logic [7:0] b);
        step_bytes.push_back(b);
    endtask

    task automatic put_crc(input logic [7:0] b);
        step_bytes.push_back(b);
        crc_acc = crc32_update(crc_acc, b);
    endtask

    task automatic put_adler(input logic [7:0] b);
        put_crc(b);
        adler_a = (adler_a + b) % ADLER_MOD;
        adler_b = (adler_b + adler_a) % ADLER_MOD;
    endtask

    task automatic put_word_plain(input logic [31:0] v);
        put_plain(v[31:24]);
        put_plain(v[23:16]);
        put_plain(v[15:8]);
        put_plain(v[7:0]);
    endtask

    task automatic put_word_crc(input logic [31:0] v);
        put_crc(v[31:24]);
        put_crc(v[23:16]);
        put_crc(v[15:8]);
        put_crc(v[7:0]);
    endtask

    task automatic open_chunk(input logic [31:0] len, input logic [31:0] tag);
        put_word_plain(len);
        crc_acc = '1;
        put_word_crc(tag);
    endtask

    task automatic close_chunk();
        put_word_plain(~crc_acc);
    endtask

    task automatic encode_pixel_byte(input logic [7:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned pitch;
        logic        last_row;
        logic        file_done;
        int          k;
        w = (width_reg == 0) ? 1 : width_reg;
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        pitch = w * (alpha_reg ? 4 : 3) + 1;
        last_row = (row_cnt + 1) >= h;
        file_done = 1'b0;
        step_bytes.delete();

        if (!image_open) begin
            put_plain(8'h89);
            put_plain("P");
            put_plain("N");
            put_plain("G");
            put_plain(8'h0d);
            put_plain(8'h0a);
            put_plain(8'h1a);
            put_plain(8'h0a);
            open_chunk(32'd13, "IHDR");
            put_word_crc(w);
            put_word_crc(h);
            put_crc(8'd8);
            put_crc(alpha_reg ? 8'd6 : 8'd2);
            put_crc(8'd0);
            put_crc(8'd0);
            put_crc(8'd0);
            close_chunk();
            open_chunk(2 + h * (5 + pitch) + 4, "IDAT");
            put_crc(8'h78);
            put_crc(8'h01);
            adler_a = 1;
            adler_b = 0;
            col_cnt = '0;
            row_cnt = '0;
            last_row = (h <= 1);
            image_open = 1'b1;
        end

        if (col_cnt == 0) begin
            put_crc({7'd0, last_row});
            put_crc(pitch[7:0]);
            put_crc(pitch[15:8]);
            put_crc(~pitch[7:0]);
            put_crc(~pitch[15:8]);
            put_adler(8'd0);
        end

        put_adler(pix);
        col_cnt = col_cnt + 16'd1;

        if (col_cnt >= pitch - 1) begin
            col_cnt = '0;
            if (last_row) begin
                put_word_crc({adler_b[15:0], adler_a[15:0]});
                close_chunk();
                open_chunk(32'd0, "IEND");
                close_chunk();
                image_open = 1'b0;
                row_cnt = '0;
                adler_a = 1;
                adler_b = 0;
                file_done = 1'b1;
            end else begin
                row_cnt = row_cnt + 15'd1;
            end
        end

        for (k = 0; k < step_bytes.size(); k++)
            png_bytes_due.push_back('{data: step_bytes[k],
                                      last: (k == step_bytes.size() - 1),
                                      fend: (k == step_bytes.size() - 1) && file_done});
    endtask

    always @(posedge clk or negedge rst_n) begin
        png_out_t due;
        if (!rst_n) begin
            width_reg = 14'd1;
            height_reg = 16'd1;
            alpha_reg = 1'b0;
            crc_acc = '1;
            adler_a = 1;
            adler_b = 0;
            col_cnt = '0;
            row_cnt = '0;
            image_open = 1'b0;
            fail_count = 0;
            png_bytes_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg = cfg_wdata[13:0];
                    REG_IMAGE_HEIGHT: height_reg = cfg_wdata[15:0];
                    REG_ALPHA_MODE:   alpha_reg = cfg_wdata[0];
                    default:          ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                encode_pixel_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (png_bytes_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected output transaction: byte %02h last %0b end %0b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    due = png_bytes_due.pop_front();
                    if (due.data !== m_axis_tdata || due.last !== m_axis_tlast ||
                        due.fend !== m_axis_tuser) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"Output mismatch: expected byte %02h last %0b end %0b, ",
                                      "got byte %02h last %0b end %0b"},
                                     due.data, due.last, due.fend,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
        end
        pending = png_bytes_due.size();
    end

endmodule

FILE: verif/tb_png_stored_stream_writer_core.sv
// Testbench top for the PNG stream writer: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_png_stored_stream_writer_core;

    import png_ssw_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   fail_count;
    int   pending;
    logic image_open;

    int   tx_idle_pct = 22;
    int   rx_idle_pct = 59;
    int   sent_count = 0;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;

    png_stored_stream_writer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    png_ssw_stream_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .image_open    (image_open)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= 5000)
                begin
                    $display("tb_png_stored_stream_writer_core failed");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_image(input logic [15:0] w, input logic [15:0] h, input logic [15:0] a);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_index <= REG_ALPHA_MODE;
        cfg_wdata <= a;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_image();
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] a;
        int          total;
        int          cut;
        w = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
        h = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
        a = 16'($urandom);
        set_image(w, h, a);
        total = ((w == 0) ? 1 : w) * (a[0] ? 4 : 3) * ((h == 0) ? 1 : h);
        if ($urandom_range(5) == 0)
        begin
            // Geometry is changed in the middle of the image and the file is run to its end.
            cut = $urandom_range(1, total);
            repeat (cut) send_byte(8'($urandom));
            if (image_open)
            begin
                set_image(16'($urandom_range(0, 4)), 16'($urandom_range(0, 2)), 16'($urandom));
                while (image_open)
                    send_byte(8'($urandom));
            end
        end
        else
        begin
            repeat (total) send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One RGB pixel with the registers as they come out of reset.
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);

        // Zero width and height act as one.
        set_image(16'd0, 16'd0, 16'h0001);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'haa);

        // Largest geometry in the header, then the image is cut short by shrinking it.
        set_image(16'hffff, 16'hffff, 16'hffff);
        send_byte(8'h01);
        send_byte(8'hfe);
        send_byte(8'h7f);
        set_image(16'd0, 16'd0, 16'h0001);
        send_byte(8'h80);

        set_image(16'd2, 16'd2, 16'h0000);
        repeat (12) send_byte(8'($urandom));

        // Output held off while the sender keeps offering a whole image.
        set_image(16'd3, 16'd2, 16'h0001);
        hold_toggle <= ~hold_toggle;
        repeat (24) send_byte(8'($urandom));

        while (sent_count < 150)
            random_image();
        tx_idle_pct = 59;
        rx_idle_pct <= 22;
        while (sent_count < 290)
            random_image();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        while (sent_count < 420)
            random_image();

        wait_drained();
        repeat (60) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_png_stored_stream_writer_core passed");
        else
            $display("tb_png_stored_stream_writer_core failed");
        $finish;
    end

endmodule

FILE: png_stored_stream_writer_core.f
hdl/png_ssw_pkg.sv
hdl/png_stored_stream_writer_core.sv
verif/png_ssw_stream_checker.sv
verif/tb_png_stored_stream_writer_core.sv
